// ===== sv/hss_pkg.sv =====
// Shared types, constants and tables for the Hall sector speed meter.
package hss_pkg;

  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam int STAMP_WIDTH        = 32;
  localparam int NUMER_WIDTH        = 32;
  localparam int SPEED_WIDTH        = 32;
  localparam int CODE_WIDTH         = 3;
  localparam int SECTOR_WIDTH       = 3;
  localparam int ANGLE_WIDTH        = 6;
  localparam int CFG_INDEX_WIDTH    = 1;
  localparam int CFG_DATA_WIDTH     = 32;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_NUMERATOR = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_OFFSET    = 1'd1;

  localparam logic [NUMER_WIDTH-1:0] NUMER_RESET  = 32'd686291313;
  localparam logic [ANGLE_WIDTH-1:0] OFFSET_RESET = 6'd0;

  // Hall codes with no sector
  localparam logic [CODE_WIDTH-1:0] HALL_ALL_LOW  = 3'd0;
  localparam logic [CODE_WIDTH-1:0] HALL_ALL_HIGH = 3'd7;

  localparam logic [SECTOR_WIDTH-1:0] SECTOR_FIRST = 3'd0;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_LAST  = 3'd5;

  localparam logic [SPEED_WIDTH-1:0] SPEED_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [SPEED_WIDTH-1:0] SPEED_NEG_SAT = 32'h8000_0000;

  localparam logic [6:0] ANGLE_MOD  = 7'd48;
  localparam logic [6:0] ANGLE_MOD2 = 7'd96;

  typedef struct packed {
    logic busy;
    logic done;
  } hss_div_stat_t;

  function automatic logic [SECTOR_WIDTH-1:0] hall_to_sector(input logic [CODE_WIDTH-1:0] code);
    logic [SECTOR_WIDTH-1:0] s;
    unique case (code)
      3'd1:    s = 3'd5;
      3'd2:    s = 3'd1;
      3'd3:    s = 3'd0;
      3'd4:    s = 3'd3;
      3'd5:    s = 3'd4;
      3'd6:    s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/hss_in_if.sv =====
// Input channel: Hall code and tick timestamp.
interface hss_in_if;
  logic                               valid;
  logic                               ready;
  logic [hss_pkg::CODE_WIDTH-1:0]     hall_code;
  logic [hss_pkg::STAMP_WIDTH-1:0]    timestamp;

  modport source (output valid, hall_code, timestamp, input ready);
  modport sink   (input valid, hall_code, timestamp, output ready);
endinterface

// ===== sv/hss_out_if.sv =====
// Output channel: sector, validity, coarse angle and speed.
interface hss_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [hss_pkg::SECTOR_WIDTH-1:0]       sector;
  logic                                   code_valid;
  logic [hss_pkg::ANGLE_WIDTH-1:0]        coarse_angle;
  logic signed [hss_pkg::SPEED_WIDTH-1:0] speed;

  modport source (output valid, sector, code_valid, coarse_angle, speed, input ready);
  modport sink   (input valid, sector, code_valid, coarse_angle, speed, output ready);
endinterface

// ===== sv/hss_cfg_if.sv =====
// Configuration write channel: register index and data.
interface hss_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [hss_pkg::CFG_INDEX_WIDTH-1:0]   index;
  logic [hss_pkg::CFG_DATA_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/hall_sector_speed_meter.sv =====
// Hall sector decode with period-based speed measurement (top level).
// Path: invalid codes and no sector step go from the input transfer straight to S_EMIT;
//   a one-sector step first runs the 32-step shared divider in S_DIV.
// Items: one at a time; the input reopens once S_EMIT has loaded the output register.
// The output register lets a new item enter while the previous result waits.
// Reset (rst, synchronous): sector/time/speed state cleared, registers to defaults.
module hall_sector_speed_meter #(
  parameter int TIME_WIDTH = hss_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  hss_in_if.sink    in_ch,
  hss_out_if.source out_ch,
  hss_cfg_if.sink   cfg_ch
);

  localparam int SW = hss_pkg::SECTOR_WIDTH;
  localparam int AW = hss_pkg::ANGLE_WIDTH;
  localparam int VW = hss_pkg::SPEED_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [hss_pkg::NUMER_WIDTH-1:0] speed_numerator;
  logic [AW-1:0]                   angle_offset;

  // persistent state
  logic [SW-1:0]         last_sector;
  logic [TIME_WIDTH-1:0] last_change_time;
  logic [VW-1:0]         held_speed;

  // captured item
  logic [SW-1:0] cur_sector;
  logic          cur_valid;
  logic          cur_fwd;
  logic          cur_zero;

  // output register
  logic          out_valid;
  logic [SW-1:0] out_sector;
  logic          out_code_valid;
  logic [AW-1:0] out_angle;
  logic [VW-1:0] out_speed;

  // decode of the incoming item
  logic                  in_xfer;
  logic                  code_ok;
  logic [SW-1:0]         dec_sector;
  logic                  step_fwd;
  logic                  step_back;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] elapsed;

  // shared divider
  logic                            div_start;
  hss_pkg::hss_div_stat_t          div_stat;
  logic [hss_pkg::NUMER_WIDTH-1:0] quotient;

  logic [VW-1:0] speed_new;
  logic [6:0]    angle_sum;
  logic [AW-1:0] angle_mod;
  logic          out_free;
  logic          emit;

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign code_ok    = (in_ch.hall_code != hss_pkg::HALL_ALL_LOW) &&
                      (in_ch.hall_code != hss_pkg::HALL_ALL_HIGH);
  assign dec_sector = hss_pkg::hall_to_sector(in_ch.hall_code);

  // one sector forward or back, wrap included; last_sector always holds 0..5
  assign step_fwd  = (dec_sector == last_sector + 1'b1) ||
                     (dec_sector == hss_pkg::SECTOR_FIRST && last_sector == hss_pkg::SECTOR_LAST);
  assign step_back = (last_sector == dec_sector + 1'b1) ||
                     (last_sector == hss_pkg::SECTOR_FIRST && dec_sector == hss_pkg::SECTOR_LAST);

  // timestamp folded to the time width, elapsed wraps modulo 2^TIME_WIDTH
  assign now     = TIME_WIDTH'(in_ch.timestamp);
  assign elapsed = now - last_change_time;

  assign div_start = in_xfer && code_ok && (step_fwd || step_back);

  hss_divider #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (speed_numerator),
    .divisor  (elapsed),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // saturate: zero interval or quotient with top bit set clips to the rail
  always_comb begin
    if (cur_fwd) begin
      speed_new = (cur_zero || quotient[VW-1]) ? hss_pkg::SPEED_POS_SAT : quotient;
    end else begin
      speed_new = (cur_zero || quotient[VW-1]) ? hss_pkg::SPEED_NEG_SAT : (VW'(0) - quotient);
    end
  end

  // (sector*8 + offset) mod 48, sum stays below 144
  always_comb begin
    angle_sum = {1'b0, cur_sector, 3'b000} + {1'b0, angle_offset};
    priority if (angle_sum >= hss_pkg::ANGLE_MOD2) begin
      angle_mod = AW'(angle_sum - hss_pkg::ANGLE_MOD2);
    end else if (angle_sum >= hss_pkg::ANGLE_MOD) begin
      angle_mod = AW'(angle_sum - hss_pkg::ANGLE_MOD);
    end else begin
      angle_mod = AW'(angle_sum);
    end
  end

  assign out_free = !out_valid || out_ch.ready;
  // a new result loads the output register this cycle
  assign emit     = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      speed_numerator  <= hss_pkg::NUMER_RESET;
      angle_offset     <= hss_pkg::OFFSET_RESET;
      last_sector      <= '0;
      last_change_time <= '0;
      held_speed       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          hss_pkg::REG_SPEED_NUMERATOR: speed_numerator <= cfg_ch.data;
          hss_pkg::REG_ANGLE_OFFSET:    angle_offset    <= AW'(cfg_ch.data);
          default: ;
        endcase
      end

      if (out_valid && out_ch.ready && !emit) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cur_valid <= code_ok;
            cur_fwd   <= step_fwd;
            cur_zero  <= (elapsed == '0);
            if (code_ok) begin
              cur_sector  <= dec_sector;
              last_sector <= dec_sector;
            end else begin
              cur_sector <= last_sector;
            end
            if (div_start) begin
              last_change_time <= now;
              state            <= S_DIV;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            held_speed <= speed_new;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_sector     <= cur_sector;
            out_code_valid <= cur_valid;
            out_angle      <= angle_mod;
            out_speed      <= held_speed;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sector       = out_sector;
  assign out_ch.code_valid   = out_code_valid;
  assign out_ch.coarse_angle = out_angle;
  assign out_ch.speed        = out_speed;

  // divider is only kicked when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // an input transfer closes the input until the item is done
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // stored sector never leaves 0..5
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    last_sector <= hss_pkg::SECTOR_LAST)
    else $error("last_sector out of range");

  // divider completion only seen while waiting on it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

endmodule

// ===== sv/hss_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module hss_divider #(
  parameter int TIME_WIDTH = hss_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hss_pkg::NUMER_WIDTH-1:0]  dividend,
  input  logic [TIME_WIDTH-1:0]            divisor,
  output hss_pkg::hss_div_stat_t           stat,
  output logic [hss_pkg::NUMER_WIDTH-1:0]  quotient
);

  localparam int NW = hss_pkg::NUMER_WIDTH;
  localparam int CW = $clog2(NW);

  logic [TIME_WIDTH-1:0] dsor;
  logic [TIME_WIDTH-1:0] rem;
  logic [NW-1:0]         quo;
  logic [CW-1:0]         count;
  logic                  busy;
  logic                  done;

  logic [TIME_WIDTH:0]   trial;
  logic [TIME_WIDTH:0]   diff;

  // shift in next dividend bit, then try the subtract
  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= '0;
        dsor  <= divisor;
        rem   <= '0;
        quo   <= dividend;
      end else if (busy) begin
        if (!diff[TIME_WIDTH]) begin
          rem <= diff[TIME_WIDTH-1:0];
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial[TIME_WIDTH-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ===== sim/sector_speed_checker.sv =====
// Checker for the Hall sector speed meter: predicts every reading and compares it.
`timescale 1ns / 100ps

module sector_speed_checker (
  input  logic clk,
  input  logic rst,
  hss_in_if    in_mon,
  hss_out_if   out_mon,
  hss_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [hss_pkg::SECTOR_WIDTH-1:0] sector;
    logic                             code_valid;
    logic [hss_pkg::ANGLE_WIDTH-1:0]  coarse_angle;
    logic [hss_pkg::SPEED_WIDTH-1:0]  speed;
  } sector_reading_t;

  sector_reading_t readings_due[$];

  logic [hss_pkg::NUMER_WIDTH-1:0]  numer;
  logic [hss_pkg::ANGLE_WIDTH-1:0]  offset;
  logic [hss_pkg::SECTOR_WIDTH-1:0] sector_seen;
  logic [hss_pkg::STAMP_WIDTH-1:0]  change_stamp;
  logic [hss_pkg::SPEED_WIDTH-1:0]  speed_held;

  initial fail_count = 0;
  initial pending = 0;

  function automatic logic [hss_pkg::SECTOR_WIDTH-1:0] sector_of_code(
      logic [hss_pkg::CODE_WIDTH-1:0] code);
    case (code)
      3'd1:    return 3'd5;
      3'd2:    return 3'd1;
      3'd3:    return 3'd0;
      3'd4:    return 3'd3;
      3'd5:    return 3'd4;
      3'd6:    return 3'd2;
      default: return hss_pkg::SECTOR_FIRST;
    endcase
  endfunction

  function automatic logic [hss_pkg::SPEED_WIDTH-1:0] period_speed(
      logic [hss_pkg::STAMP_WIDTH-1:0] elapsed, logic forward);
    logic [hss_pkg::NUMER_WIDTH-1:0] quot;
    if (elapsed == 0) return forward ? hss_pkg::SPEED_POS_SAT : hss_pkg::SPEED_NEG_SAT;
    quot = numer / elapsed;
    if (forward) return (quot > hss_pkg::SPEED_POS_SAT) ? hss_pkg::SPEED_POS_SAT : quot;
    if (quot >= hss_pkg::SPEED_NEG_SAT) return hss_pkg::SPEED_NEG_SAT;
    return 32'd0 - quot;
  endfunction

  // Updates the tracked sector state and returns the reading it produces.
  function automatic sector_reading_t predict_reading(
      logic [hss_pkg::CODE_WIDTH-1:0] code, logic [hss_pkg::STAMP_WIDTH-1:0] stamp);
    sector_reading_t                  rd;
    logic [hss_pkg::SECTOR_WIDTH-1:0] sec;
    logic                             ok;
    int                               step;
    int                               angle;
    ok  = (code != hss_pkg::HALL_ALL_LOW) && (code != hss_pkg::HALL_ALL_HIGH);
    sec = sector_seen;
    if (ok) begin
      sec  = sector_of_code(code);
      step = (int'(sec) + 6 - int'(sector_seen)) % 6;
      if (step == 1 || step == 5) begin
        speed_held   = period_speed(stamp - change_stamp, step == 1);
        change_stamp = stamp;
      end
      sector_seen = sec;
    end
    angle           = (int'(sec) * 8 + int'(offset)) % 48;
    rd.sector       = sec;
    rd.code_valid   = ok;
    rd.coarse_angle = angle[hss_pkg::ANGLE_WIDTH-1:0];
    rd.speed        = speed_held;
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s check failed, expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sector_reading_t want;
    if (rst) begin
      numer        = hss_pkg::NUMER_RESET;
      offset       = hss_pkg::OFFSET_RESET;
      sector_seen  = hss_pkg::SECTOR_FIRST;
      change_stamp = '0;
      speed_held   = '0;
      readings_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          hss_pkg::REG_SPEED_NUMERATOR: numer = cfg_mon.data;
          hss_pkg::REG_ANGLE_OFFSET:    offset = cfg_mon.data[hss_pkg::ANGLE_WIDTH-1:0];
          default: ;
        endcase
      end
      // results leave before the same-edge input is predicted
      if (out_mon.valid && out_mon.ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected result, speed", '0, out_mon.speed);
        end else begin
          want = readings_due.pop_front();
          if (out_mon.sector !== want.sector)
            report_mismatch("sector", want.sector, out_mon.sector);
          if (out_mon.code_valid !== want.code_valid)
            report_mismatch("code_valid", want.code_valid, out_mon.code_valid);
          if (out_mon.coarse_angle !== want.coarse_angle)
            report_mismatch("coarse_angle", want.coarse_angle, out_mon.coarse_angle);
          if (out_mon.speed !== want.speed)
            report_mismatch("speed", want.speed, out_mon.speed);
        end
      end
      if (in_mon.valid && in_mon.ready)
        readings_due.push_back(predict_reading(in_mon.hall_code, in_mon.timestamp));
    end
    pending <= readings_due.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the Hall sector speed meter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;

  logic clk;
  logic rst;

  hss_in_if  in_ch();
  hss_out_if out_ch();
  hss_cfg_if cfg_ch();

  int fail_count;
  int pending;

  // flow control knobs, in percent of cycles
  int send_idle_pct;
  int stall_pct;

  // stimulus-side view of the rotor: where the generator thinks it is
  int                              gen_sector;
  logic                            spin_fwd;
  logic [hss_pkg::STAMP_WIDTH-1:0] ts_now;

  hall_sector_speed_meter DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sector_speed_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver side: ready changes on the falling edge only, so a stall can
  // land on any cycle of the divider run or of the output hold.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hall code that puts the rotor in a given sector (inverse of the decode table).
  function automatic logic [hss_pkg::CODE_WIDTH-1:0] hall_code_for(int sec);
    case (sec)
      0:       return 3'd3;
      1:       return 3'd2;
      2:       return 3'd6;
      3:       return 3'd4;
      4:       return 3'd5;
      default: return 3'd1;
    endcase
  endfunction

  // One sample transfer on the input channel. Called at a falling edge,
  // returns at the falling edge after the transfer. Valid stays high when
  // the next sample follows with no gap.
  task automatic send_sample(input logic [hss_pkg::CODE_WIDTH-1:0] code,
                             input logic [hss_pkg::STAMP_WIDTH-1:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.hall_code <= code;
    in_ch.timestamp <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [hss_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [hss_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Every sample yields a reading, so once nothing is owed the block is idle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Offset register write with junk in the unused upper data bits.
  task automatic write_offset(input int off);
    write_reg(hss_pkg::REG_ANGLE_OFFSET, ($urandom & ~32'h3F) | 32'(off));
  endtask

  // Watchdog: far beyond the slowest legal run (~1100 samples, each at most one
  // divider pass plus stalls, is well under a millisecond).
  initial begin
    #5000000;
    $display("hall_sector_speed_meter: mismatch");
    $finish;
  end

  initial begin
    int pick;
    int nxt;
    logic [hss_pkg::CODE_WIDTH-1:0] code;

    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.hall_code = '0;
    in_ch.timestamp = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    spin_fwd        = 1'b1;
    ts_now          = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- Directed part, reset register values first ----
    send_sample(hss_pkg::HALL_ALL_LOW, 32'h0000_0000);   // invalid code, state untouched
    send_sample(hss_pkg::HALL_ALL_HIGH, 32'hFFFF_FFFF);  // other invalid code
    send_sample(hall_code_for(0), 32'd5);        // same sector as reset: speed held
    send_sample(hall_code_for(1), 32'd0);        // forward, zero interval -> saturate
    send_sample(hall_code_for(2), 32'd1);        // forward, one tick: full numerator
    send_sample(hall_code_for(1), 32'hFFFF_FFFF); // backward, huge interval -> 0
    send_sample(hall_code_for(3), 32'd100);      // jump of two: held
    send_sample(hall_code_for(0), 32'd200);      // jump of three: held
    send_sample(hall_code_for(5), 32'hFFFF_FFFF); // wrap back 0->5, zero interval
    send_sample(hall_code_for(0), 32'h0000_0010); // wrap forward 5->0 across ts wrap

    // Largest numerator, offset at the top of the register range.
    wait_drained();
    write_reg(hss_pkg::REG_SPEED_NUMERATOR, 32'hFFFF_FFFF);
    write_offset(63);
    cfg_ch.valid <= 1'b0;
    send_sample(hall_code_for(1), 32'h11);       // quotient too big forward
    send_sample(hall_code_for(0), 32'h12);       // quotient too big backward
    send_sample(hall_code_for(1), 32'h14);       // quotient exactly max positive
    send_sample(hall_code_for(0), 32'h16);       // negative of max positive
    send_sample(hall_code_for(5), 32'h19);

    // Zero numerator, offset of exactly one turn.
    wait_drained();
    write_reg(hss_pkg::REG_SPEED_NUMERATOR, 32'h0000_0000);
    write_offset(48);
    cfg_ch.valid <= 1'b0;
    send_sample(hall_code_for(4), 32'h20);
    send_sample(hall_code_for(3), 32'h20);
    send_sample(hss_pkg::HALL_ALL_LOW, 32'h5A5A_A5A5);

    // Quotient of exactly 2^31: backward boundary and forward clamp.
    wait_drained();
    write_reg(hss_pkg::REG_SPEED_NUMERATOR, 32'h8000_0000);
    write_offset(47);
    cfg_ch.valid <= 1'b0;
    send_sample(hall_code_for(2), 32'h21);
    send_sample(hall_code_for(3), 32'h22);
    send_sample(hall_code_for(4), 32'h24);
    gen_sector = 4;
    ts_now     = 32'h24;

    // ---- Random part: eight phases, each with its own settings and idling ----
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_reg(hss_pkg::REG_SPEED_NUMERATOR, hss_pkg::NUMER_RESET);
          write_offset(0);
        end
        1: begin
          write_offset(47);
          write_reg(hss_pkg::REG_SPEED_NUMERATOR, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(hss_pkg::REG_SPEED_NUMERATOR, 32'h0000_0000);
          write_offset(63);
        end
        3: begin
          write_offset(48);
          write_reg(hss_pkg::REG_SPEED_NUMERATOR, $urandom);
        end
        5: begin
          // small numerator: speeds near zero and lots of truncation
          write_reg(hss_pkg::REG_SPEED_NUMERATOR, $urandom_range(1, 4000));
          write_offset($urandom_range(0, 63));
        end
        default: begin
          write_reg(hss_pkg::REG_SPEED_NUMERATOR, $urandom);
          write_offset($urandom_range(0, 63));
        end
      endcase
      cfg_ch.valid <= 1'b0;

      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase

      for (int n = 0; n < 132; n++) begin
        // Time moves on mostly by small amounts; now and then not at all
        // (zero interval on the next step) or by a big random jump.
        pick = $urandom_range(0, 99);
        if (pick < 5)       ts_now = ts_now;
        else if (pick < 80) ts_now = ts_now + $urandom_range(1, 2000);
        else if (pick < 92) ts_now = ts_now + $urandom_range(2001, 1 << 20);
        else                ts_now = $urandom;

        // Mostly a rotor turning one way, with reversals, dwell, jumps and
        // bad sensor codes mixed in.
        if ($urandom_range(0, 99) < 3) spin_fwd = ~spin_fwd;
        pick = $urandom_range(0, 99);
        if (pick < 92) begin
          if (pick < 70)      nxt = spin_fwd ? gen_sector + 1 : gen_sector + 5;
          else if (pick < 78) nxt = spin_fwd ? gen_sector + 5 : gen_sector + 1;
          else if (pick < 86) nxt = gen_sector;
          else                nxt = gen_sector + $urandom_range(2, 4);
          gen_sector = nxt % 6;
          code = hall_code_for(gen_sector);
        end else begin
          code = $urandom_range(0, 1) ? hss_pkg::HALL_ALL_HIGH : hss_pkg::HALL_ALL_LOW;
        end
        send_sample(code, ts_now);
      end
    end

    // Drain, then give the divider a full pass worth of margin.
    wait_drained();
    repeat (40) @(negedge clk);

    if (fail_count == 0) begin
      $display("hall_sector_speed_meter: match");
    end else begin
      $display("hall_sector_speed_meter: mismatch");
    end
    $finish;
  end

endmodule

// ===== hall_sector_speed_meter.f =====
sv/hss_pkg.sv
sv/hss_in_if.sv
sv/hss_out_if.sv
sv/hss_cfg_if.sv
sv/hss_divider.sv
sv/hall_sector_speed_meter.sv
sim/sector_speed_checker.sv
sim/tb.sv
